FILE: hw/rtl/assert_macros.svh
// Assertion macros of the Code 128 B serializer, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/cbs_pkg.sv
// Package of the Code 128 B serializer: constants, symbol table, job type.
package cbs_pkg;

  localparam int unsigned SYM_W     = 7;
  localparam int unsigned PAT_W     = 13;
  localparam int unsigned CNT_W     = 4;

  localparam logic [CNT_W-1:0] SYM_MODULES  = 4'd11;
  localparam logic [CNT_W-1:0] STOP_MODULES = 4'd13;
  localparam logic [PAT_W-1:0] START_B_PAT  = 13'h004B;
  localparam logic [PAT_W-1:0] STOP_PAT     = 13'h1AE3;
  localparam logic [SYM_W-1:0] CSUM_MOD     = 7'd103;
  localparam logic [SYM_W-1:0] CSUM_INIT    = 7'd1;   // 104 mod 103
  localparam logic [SYM_W-1:0] QMARK_SYM    = 7'd31;
  localparam logic [7:0]       SYM_OFFSET   = 8'h20;
  localparam logic [7:0]       SYM_COUNT_B  = 8'h60;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Symbol patterns, least significant module first.
  localparam logic [10:0] SYM_PAT [103] = '{
    11'h19B, 11'h1B3, 11'h333, 11'h0C9, 11'h189, 11'h191, 11'h099, 11'h119,
    11'h131, 11'h093, 11'h113, 11'h123, 11'h1CD, 11'h1D9, 11'h399, 11'h19D,
    11'h1B9, 11'h339, 11'h273, 11'h1D3, 11'h393, 11'h13B, 11'h173, 11'h3B7,
    11'h197, 11'h1A7, 11'h327, 11'h137, 11'h167, 11'h267, 11'h0DB, 11'h31B,
    11'h363, 11'h0C5, 11'h0D1, 11'h311, 11'h08D, 11'h0B1, 11'h231, 11'h08B,
    11'h0A3, 11'h223, 11'h0ED, 11'h38D, 11'h3B1, 11'h0DD, 11'h31D, 11'h371,
    11'h377, 11'h38B, 11'h3A3, 11'h0BB, 11'h23B, 11'h3BB, 11'h0D7, 11'h317,
    11'h347, 11'h0B7, 11'h237, 11'h2C7, 11'h2F7, 11'h213, 11'h28F, 11'h065,
    11'h185, 11'h069, 11'h309, 11'h1A1, 11'h321, 11'h04D, 11'h10D, 11'h059,
    11'h219, 11'h161, 11'h261, 11'h243, 11'h053, 11'h2EF, 11'h143, 11'h2F1,
    11'h1E5, 11'h1E9, 11'h3C9, 11'h13D, 11'h179, 11'h279, 11'h12F, 11'h14F,
    11'h24F, 11'h3DB, 11'h37B, 11'h36F, 11'h0F5, 11'h3C5, 11'h3D1, 11'h0BD,
    11'h23D, 11'h0AF, 11'h22F, 11'h3DD, 11'h3BD, 11'h3D7, 11'h3AF
  };

  // Pattern of a symbol value, widened to the serializer width.
  function automatic logic [PAT_W-1:0] sym_pattern(logic [SYM_W-1:0] s);
    logic [PAT_W-1:0] p;
    p = '0;
    if (s < CSUM_MOD) begin
      p = {2'b00, SYM_PAT[s]};
    end
    return p;
  endfunction

  // Table of (h * 128) mod 103 for the high part of a checksum sum.
  typedef logic [SYM_W-1:0] hi_mod_tbl_t [128];

  function automatic hi_mod_tbl_t gen_hi_mod();
    hi_mod_tbl_t t;
    logic [7:0]  r;
    r = '0;
    for (int i = 0; i < 128; i++) begin
      t[i] = r[SYM_W-1:0];
      r = r + 8'd25;                 // 128 mod 103
      if (r >= {1'b0, CSUM_MOD}) begin
        r = r - {1'b0, CSUM_MOD};
      end
    end
    return t;
  endfunction

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic             need_start;  // start B pattern goes first
    logic             is_end;      // sym is the checksum, stop pattern follows
    logic [SYM_W-1:0] sym;
  } cbs_job_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } cbs_qstat_t;

endpackage

FILE: hw/rtl/code128b_bar_serializer.sv
// Top level of the Code 128 subset B bar serializer.
//
//  channel   | dir | tdata            | tlast         | tuser
//  s_axis    | in  | [7:0] char_code  | -             | [0] mode (1 = end)
//  m_axis    | out | [0] bar          | last_of_item  | [0] barcode_done
//
// One module leaves per cycle from the back serializer: a character is
// 11 modules (22 when it opens a barcode), an end item 24 (35 when opening).
// The front classifies an item into a stage register, parks it in the job
// queue, so input is taken while the back still serializes earlier items.
// Reset clears control state; checksum restarts at 104 mod 103.
// Output stalls hold the serializer; a full queue stalls the input.
`include "assert_macros.svh"

module code128b_bar_serializer #(
  parameter int unsigned QueueDepth = cbs_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tuser_i,   // [0] mode
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] bar, [7:1] zero
  output logic       m_axis_tlast_o,   // last_of_item
  output logic       m_axis_tuser_o    // [0] barcode_done
);
  import cbs_pkg::*;

  logic       q_push, q_pop;
  cbs_job_t   push_job, pop_job;
  cbs_qstat_t qstat;

  cbs_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .qstat_i    (qstat),
    .push_o     (q_push),
    .push_job_o (push_job)
  );

  cbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .stat_o     (qstat)
  );

  cbs_back u_back (
    .clk_i,
    .rst_ni,
    .qstat_i   (qstat),
    .pop_job_i (pop_job),
    .pop_o     (q_pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o,
    .m_axis_tuser_o
  );

  // Checks
  `ASSERT_NEVER(a_push_full, q_push && qstat.full, "job pushed into full queue")
  `ASSERT_NEVER(a_pop_empty, q_pop && qstat.empty, "job popped from empty queue")
  `ASSERT_CLK(a_csum_range, (q_push && push_job.is_end) |-> (push_job.sym < CSUM_MOD), "checksum symbol out of range")
  `ASSERT_CLK(a_done_last, (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o, "barcode end without item end")

endmodule

FILE: hw/rtl/cbs_queue.sv
// Small register queue of classified jobs between front and back.
module cbs_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbs_pkg::cbs_job_t push_job_i,
  input  logic              pop_i,
  output cbs_pkg::cbs_job_t pop_job_o,
  output cbs_pkg::cbs_qstat_t stat_o
);
  import cbs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cbs_job_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  assign pop_job_o    = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

endmodule

FILE: hw/rtl/cbs_front.sv
// Front end: accepts characters, maps them to symbols, keeps the checksum.
module cbs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] char_code
  input  logic               s_axis_tuser_i,   // [0] mode
  input  cbs_pkg::cbs_qstat_t qstat_i,
  output logic               push_o,
  output cbs_pkg::cbs_job_t  push_job_o
);
  import cbs_pkg::*;

  localparam hi_mod_tbl_t HiMod = gen_hi_mod();
  localparam logic [SYM_W-1:0] LastWeight = CSUM_MOD - 7'd1;

  logic             accept;
  logic [7:0]       sym_raw;
  logic [SYM_W-1:0] sym_in;
  logic [SYM_W-1:0] w_use;

  logic             a_valid_q, a_valid_d;
  logic             a_mode_q, a_start_q;
  logic [SYM_W-1:0] a_sym_q;
  logic [13:0]      a_prod_q;
  logic             started_q, started_d;
  logic [SYM_W-1:0] w_q, w_d;
  logic [SYM_W-1:0] cs_q, cs_d;

  logic [13:0]      sum;
  logic [7:0]       part;
  logic [SYM_W-1:0] cs_new;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !a_valid_q || !qstat_i.full;
  assign push_o          = a_valid_q && !qstat_i.full;

  // Character to symbol, out-of-set bytes become '?'
  assign sym_raw = s_axis_tdata_i - SYM_OFFSET;
  assign sym_in  = (sym_raw >= SYM_COUNT_B) ? QMARK_SYM : sym_raw[SYM_W-1:0];

  // Weight of this character, restarting at 1 in a new barcode
  assign w_use = !started_q        ? 7'd1 :
                 (w_q == LastWeight) ? '0 : w_q + 7'd1;

  always_comb begin
    started_d = started_q;
    w_d       = w_q;
    if (accept) begin
      started_d = !s_axis_tuser_i;
      w_d       = s_axis_tuser_i ? '0 : w_use;
    end
  end

  // Stage register: weighted symbol product
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_mode_q  <= s_axis_tuser_i;
      a_start_q <= !started_q;
      a_sym_q   <= sym_in;
      a_prod_q  <= {7'd0, w_use} * {7'd0, sym_in};
    end
  end

  // Checksum add and mod 103 reduction via split table
  always_comb begin
    sum  = a_prod_q + {7'd0, cs_q};
    part = {1'b0, HiMod[sum[13:7]]} + {1'b0, sum[6:0]};
    if (part >= {CSUM_MOD, 1'b0}) begin
      part = part - {CSUM_MOD, 1'b0};
    end else if (part >= {1'b0, CSUM_MOD}) begin
      part = part - {1'b0, CSUM_MOD};
    end
    cs_new = part[SYM_W-1:0];
  end

  always_comb begin
    cs_d = cs_q;
    if (push_o) begin
      cs_d = a_mode_q ? CSUM_INIT : cs_new;
    end
    a_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : a_valid_q);
  end

  assign push_job_o.need_start = a_start_q;
  assign push_job_o.is_end     = a_mode_q;
  assign push_job_o.sym        = a_mode_q ? cs_q : a_sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      started_q <= 1'b0;
      w_q       <= '0;
      cs_q      <= CSUM_INIT;
    end else begin
      a_valid_q <= a_valid_d;
      started_q <= started_d;
      w_q       <= w_d;
      cs_q      <= cs_d;
    end
  end

endmodule

FILE: hw/rtl/cbs_back.sv
// Back end: serializes start, symbol and stop patterns one module per cycle while the output has room.
module cbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbs_pkg::cbs_qstat_t qstat_i,
  input  cbs_pkg::cbs_job_t  pop_job_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [0] bar, [7:1] zero
  output logic               m_axis_tlast_o,   // last_of_item
  output logic               m_axis_tuser_o    // [0] barcode_done
);
  import cbs_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_SYM   = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  logic             busy_q, busy_d;
  logic [1:0]       phase_q, phase_d;
  logic [PAT_W-1:0] shift_q, shift_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             end_q, end_d;
  logic             out_valid_q, out_valid_d;
  logic             bar_q, bar_d, last_q, last_d, done_q, done_d;

  logic out_room, emit, pattern_end, item_end, stop_end;

  assign out_room    = !out_valid_q || m_axis_tready_i;
  assign emit        = busy_q && out_room;
  assign pattern_end = emit && (cnt_q == 4'd1);
  assign stop_end    = pattern_end && (phase_q == PH_STOP);
  assign item_end    = stop_end || (pattern_end && (phase_q == PH_SYM) && !end_q);
  assign pop_o       = (!busy_q || item_end) && !qstat_i.empty;

  // Serializer next state
  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    sym_d       = sym_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    bar_d       = bar_q;
    last_d      = last_q;
    done_d      = done_q;

    if (emit) begin
      out_valid_d = 1'b1;
      bar_d       = shift_q[0];
      last_d      = item_end;
      done_d      = stop_end;
      shift_d     = shift_q >> 1;
      cnt_d       = cnt_q - 4'd1;
    end

    // Chain to the next pattern of this transaction
    if (pattern_end) begin
      case (phase_q)
        PH_START: begin
          phase_d = PH_SYM;
          shift_d = sym_pattern(sym_q);
          cnt_d   = SYM_MODULES;
        end
        PH_SYM: begin
          if (end_q) begin
            phase_d = PH_STOP;
            shift_d = STOP_PAT;
            cnt_d   = STOP_MODULES;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end

    // Load the next job
    if (pop_o) begin
      busy_d  = 1'b1;
      sym_d   = pop_job_i.sym;
      end_d   = pop_job_i.is_end;
      cnt_d   = SYM_MODULES;
      if (pop_job_i.need_start) begin
        phase_d = PH_START;
        shift_d = START_B_PAT;
      end else begin
        phase_d = PH_SYM;
        shift_d = sym_pattern(pop_job_i.sym);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_START;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    sym_q   <= sym_d;
    end_q   <= end_d;
    bar_q   <= bar_d;
    last_q  <= last_d;
    done_q  <= done_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, bar_q};
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = done_q;

endmodule

FILE: tb/tb_code128b_bar_serializer.sv
// Self-checking testbench of the Code 128 B bar serializer.
module tb_code128b_bar_serializer;

  // Item kinds carried in s_axis_tuser
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic [12:0] START_B_BITS = 13'h004B;
  localparam logic [12:0] STOP_BITS    = 13'h1AE3;
  localparam logic [7:0]  QMARK_VAL    = 8'd31;
  localparam int          PAT_LEN      = 11;
  localparam int          STOP_LEN     = 13;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          RAND_ITEMS   = 200;
  localparam int          DIR_ROWS     = 14;

  // Code 128 symbol patterns, least significant module first
  localparam logic [10:0] SYM_BITS [103] = '{
    11'h19B, 11'h1B3, 11'h333, 11'h0C9, 11'h189, 11'h191, 11'h099, 11'h119,
    11'h131, 11'h093, 11'h113, 11'h123, 11'h1CD, 11'h1D9, 11'h399, 11'h19D,
    11'h1B9, 11'h339, 11'h273, 11'h1D3, 11'h393, 11'h13B, 11'h173, 11'h3B7,
    11'h197, 11'h1A7, 11'h327, 11'h137, 11'h167, 11'h267, 11'h0DB, 11'h31B,
    11'h363, 11'h0C5, 11'h0D1, 11'h311, 11'h08D, 11'h0B1, 11'h231, 11'h08B,
    11'h0A3, 11'h223, 11'h0ED, 11'h38D, 11'h3B1, 11'h0DD, 11'h31D, 11'h371,
    11'h377, 11'h38B, 11'h3A3, 11'h0BB, 11'h23B, 11'h3BB, 11'h0D7, 11'h317,
    11'h347, 11'h0B7, 11'h237, 11'h2C7, 11'h2F7, 11'h213, 11'h28F, 11'h065,
    11'h185, 11'h069, 11'h309, 11'h1A1, 11'h321, 11'h04D, 11'h10D, 11'h059,
    11'h219, 11'h161, 11'h261, 11'h243, 11'h053, 11'h2EF, 11'h143, 11'h2F1,
    11'h1E5, 11'h1E9, 11'h3C9, 11'h13D, 11'h179, 11'h279, 11'h12F, 11'h14F,
    11'h24F, 11'h3DB, 11'h37B, 11'h36F, 11'h0F5, 11'h3C5, 11'h3D1, 11'h0BD,
    11'h23D, 11'h0AF, 11'h22F, 11'h3DD, 11'h3BD, 11'h3D7, 11'h3AF
  };

  // One expected module
  typedef struct packed {
    logic bar;
    logic last;
    logic done;
  } module_exp_t;

  // One stimulus row; with typed set, up to three patterns are given by hand
  typedef struct {
    logic        mode;
    logic [7:0]  code;
    bit          typed;
    logic [12:0] p0;
    int          n0;
    logic [12:0] p1;
    int          n1;
    logic [12:0] p2;
    int          n2;
  } bar_row_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       s_valid     = 1'b0;
  logic [7:0] s_data      = 8'h00;
  logic       s_user      = 1'b0;
  logic       m_ready     = 1'b0;
  logic       s_tready_o;
  logic       m_tvalid_o;
  logic [7:0] m_tdata_o;
  logic       m_tlast_o;
  logic       m_tuser_o;

  module_exp_t module_expect_q [$];

  // Predicted barcode state
  logic       pr_started = 1'b0;
  logic [6:0] pr_csum    = 7'd1;
  logic [6:0] pr_weight  = 7'd0;

  bar_row_t cur_row;
  int cycles       = 0;
  int errors       = 0;
  int items_sent   = 0;
  int modules_seen = 0;
  int barcodes     = 0;
  int burst_left   = 0;

  // Directed rows: hand-typed where the patterns are plain to see
  bar_row_t dir_tbl [DIR_ROWS] = '{
    // space opens a barcode: start B then symbol 0
    '{MODE_CHAR, 8'h20, 1, START_B_BITS, PAT_LEN, 13'h19B, PAT_LEN, 13'h0, 0},
    // checksum (104 + 1*0) mod 103 = 1
    '{MODE_END,  8'h00, 1, 13'h1B3, PAT_LEN, STOP_BITS, STOP_LEN, 13'h0, 0},
    // empty text: start B, checksum 1, stop
    '{MODE_END,  8'hFF, 1, START_B_BITS, PAT_LEN, 13'h1B3, PAT_LEN, STOP_BITS, STOP_LEN},
    // control bytes and high bytes turn into '?', while 7F keeps symbol 95
    '{MODE_CHAR, 8'h00, 1, START_B_BITS, PAT_LEN, 13'h31B, PAT_LEN, 13'h0, 0},
    '{MODE_CHAR, 8'h1F, 1, 13'h31B, PAT_LEN, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'h7F, 1, 13'h0BD, PAT_LEN, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'h80, 1, 13'h31B, PAT_LEN, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'hFF, 1, 13'h31B, PAT_LEN, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'h3F, 1, 13'h31B, PAT_LEN, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'h41, 0, 13'h0, 0, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'h7E, 0, 13'h0, 0, 13'h0, 0, 13'h0, 0},
    '{MODE_END,  8'h55, 0, 13'h0, 0, 13'h0, 0, 13'h0, 0},
    '{MODE_CHAR, 8'h5A, 0, 13'h0, 0, 13'h0, 0, 13'h0, 0},
    '{MODE_END,  8'hAA, 0, 13'h0, 0, 13'h0, 0, 13'h0, 0}
  };

  code128b_bar_serializer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata_o),
    .m_axis_tlast_o  (m_tlast_o),
    .m_axis_tuser_o  (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append the modules of one pattern; flags go on its final module
  task automatic queue_pattern(input logic [12:0] bits, input int count,
                               input logic last, input logic done);
    module_exp_t e;
    for (int i = 0; i < count; i++) begin
      e.bar  = bits[i];
      e.last = last && (i == count - 1);
      e.done = done && (i == count - 1);
      module_expect_q.push_back(e);
    end
  endtask

  // Advance the barcode state by one item and, if keep, queue its modules
  task automatic predict_modules(input logic mode, input logic [7:0] code, input bit keep);
    logic [7:0] sym;
    int         w;
    if (!pr_started) begin
      if (keep) queue_pattern(START_B_BITS, PAT_LEN, 1'b0, 1'b0);
      pr_started = 1'b1;
      pr_csum    = 7'd1;
      pr_weight  = 7'd0;
    end
    if (mode == MODE_CHAR) begin
      sym = code - 8'h20;
      if (sym >= 8'h60) sym = QMARK_VAL;
      w = (int'(pr_weight) + 1) % 103;
      pr_weight = 7'(w);
      pr_csum   = 7'((w * int'(sym) + int'(pr_csum)) % 103);
      if (keep) queue_pattern({2'b00, SYM_BITS[sym]}, PAT_LEN, 1'b1, 1'b0);
    end else begin
      if (keep) begin
        queue_pattern({2'b00, SYM_BITS[pr_csum]}, PAT_LEN, 1'b0, 1'b0);
        queue_pattern(STOP_BITS, STOP_LEN, 1'b1, 1'b1);
      end
      pr_started = 1'b0;
      pr_csum    = 7'd1;
      pr_weight  = 7'd0;
    end
  endtask

  // Present one item in bursts with random gaps; returns at the next falling edge
  task automatic send_item(input bar_row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    cur_row = r;
    s_valid <= 1'b1;
    s_data  <= r.code;
    s_user  <= r.mode;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
    @(negedge clk_i);
  endtask

  // Receiver backpressure, style drawn anew whenever its run counter runs out
  int   rx_left  = 0;
  int   rx_style = 0;
  int   rx_hold  = 0;
  int   rx_tick  = 0;
  logic rx_level = 1'b0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left  = $urandom_range(64, 256);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_style)
      0: begin
        m_ready <= 1'b1;
      end
      1: begin
        m_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = rx_level ? $urandom_range(1, 8) : $urandom_range(1, 25);
        end
        rx_hold--;
        m_ready <= rx_level;
      end
      default: begin
        m_ready <= (rx_tick % 3 == 0);
      end
    endcase
  end

  // Predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    module_exp_t e;
    if (rst_ni) begin
      cycles++;
      if (s_valid && s_tready_o) begin
        predict_modules(cur_row.mode, cur_row.code, !cur_row.typed);
        if (cur_row.typed) begin
          queue_pattern(cur_row.p0, cur_row.n0, cur_row.n1 == 0,
                        (cur_row.n1 == 0) && cur_row.mode);
          queue_pattern(cur_row.p1, cur_row.n1, cur_row.n2 == 0,
                        (cur_row.n2 == 0) && cur_row.mode);
          queue_pattern(cur_row.p2, cur_row.n2, 1'b1, cur_row.mode);
        end
      end
      if (m_tvalid_o && m_ready) begin
        modules_seen++;
        if (m_tuser_o) barcodes++;
        if (module_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected module: tdata=%h tlast=%b tuser=%b",
                   $time, m_tdata_o, m_tlast_o, m_tuser_o);
        end else begin
          e = module_expect_q.pop_front();
          if (m_tdata_o !== {7'b0, e.bar}) begin
            errors++;
            $display("%0t: bar mismatch: expected %h, actual %h", $time, {7'b0, e.bar},
                     m_tdata_o);
          end
          if (m_tlast_o !== e.last) begin
            errors++;
            $display("%0t: last_of_item mismatch: expected %b, actual %b", $time, e.last,
                     m_tlast_o);
          end
          if (m_tuser_o !== e.done) begin
            errors++;
            $display("%0t: barcode_done mismatch: expected %b, actual %b", $time, e.done,
                     m_tuser_o);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d modules outstanding", $time, module_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Main stimulus
  initial begin
    bar_row_t r;
    int       rand_items;
    int       bc_idx;
    int       text_len;
    rand_items = 0;
    bc_idx     = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_tbl[i]);

    // Random barcodes, one long enough to wrap the character weight
    r = dir_tbl[DIR_ROWS - 1];
    r.typed = 1'b0;
    while (rand_items < RAND_ITEMS) begin
      text_len = (bc_idx == 3) ? $urandom_range(104, 110) : $urandom_range(0, 8);
      for (int k = 0; k < text_len; k++) begin
        r.mode = MODE_CHAR;
        r.code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h20, 8'h7F))
                                             : 8'($urandom_range(0, 255));
        send_item(r);
        rand_items++;
      end
      r.mode = MODE_END;
      r.code = 8'($urandom_range(0, 255));
      send_item(r);
      rand_items++;
      bc_idx++;
    end
    s_valid <= 1'b0;

    while (module_expect_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Sent %0d items (%0d random) over %0d barcodes; %0d modules checked",
             items_sent, rand_items, barcodes, modules_seen);
    $display("Directed extremes, control and high bytes, empty text, weight wrap; %0d errors",
             errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
